// ===== sv/hcbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int SYM_W        = 8;
	localparam int CODE_W       = 32;
	localparam int LEN_IN_W     = 6;
	localparam int BYTE_W       = 8;
	localparam int PAD_W        = 3;
	localparam int FUNC_W       = 2;
	localparam int IN_TDATA_W   = 48;
	localparam int OUT_TUSER_W  = 3;

	localparam int DEF_MAX_CODE_LEN = 32;
	localparam int DEF_SYMBOL_COUNT = 256;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FLUSH  = 2'd2
	} func_t;

endpackage

// ===== sv/hcbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder back end: code table RAM plus MSB-first bit packer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes requests; tuser[1:0] is the function (load, encode,
//   flush), tdata carries symbol, code_value and code_length. A load writes
//   the code table RAM and produces nothing. An encode reads the table and
//   appends the code to the bit accumulator; each full byte goes out on the
//   master stream, earliest bit in bit 7, tlast on the request's final byte.
//   A flush emits the partial byte zero padded, tuser = pad bit count.
// Path: RAM read, accumulator merge and output register lie between request
//   accept and the first byte on the master side.
// Throughput: one output byte per cycle while m_axis_tready is high. A
//   request is taken every cycle in which the accumulator drains below 8 bits,
//   so a request waits while earlier encoded bytes are still being drained.
// Reset: clears the accumulator bit count, pad count and pipeline valids; the
//   code table is not cleared and must be loaded before use.
// Stall: the output register holds while m_axis_tready is low; the
//   accumulator and input stage fill and then tready drops.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer
	import hcbp_pkg::*;
#(
	parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [7:0] symbol, [39:8] code_value, [45:40] code_length, [47:46] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] func
	input  logic [FUNC_W-1:0]      s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [7:0] out_byte
	output logic [BYTE_W-1:0]      m_axis_tdata,
	// last_of_run
	output logic                   m_axis_tlast,
	// [2:0] pad_bits
	output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	localparam int LenLimit = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int ACC_W    = LenLimit + BYTE_W - 1;
	localparam int CNT_W    = $clog2(ACC_W + 1);
	localparam int LEN_W    = $clog2(LenLimit + 1);
	localparam int AW       = $clog2(SYMBOL_COUNT);
	localparam int ENT_W    = CODE_W + LEN_IN_W;

	func_t                func_in;
	logic [SYM_W-1:0]     sym_in;
	logic [CODE_W-1:0]    code_in;
	logic [LEN_IN_W-1:0]  len_in;
	logic [LEN_IN_W-1:0]  len_sat;
	logic                 sym_hit;
	logic                 in_ok;
	logic                 wr_en;
	logic                 rd_en;
	logic [ENT_W-1:0]     rd_data;

	logic                 valid_s1;
	logic                 flush_s1;
	logic                 hit_s1;

	logic [ACC_W-1:0]     acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PAD_W-1:0]     pad_q;

	logic                 emit;
	logic [CNT_W-1:0]     cnt_after;
	logic                 take;
	logic [LEN_IN_W-1:0]  len_rd;
	logic [LEN_W-1:0]     len_use;
	logic [CODE_W-1:0]    code_m;
	logic [ACC_W-1:0]     emit_sh;

	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 out_last_q;
	logic [PAD_W-1:0]     out_pad_q;

	assign func_in = func_t'(s_axis_tuser);
	assign sym_in  = s_axis_tdata[SYM_W-1:0];
	assign code_in = s_axis_tdata[SYM_W +: CODE_W];
	assign len_in  = s_axis_tdata[SYM_W + CODE_W +: LEN_IN_W];
	assign sym_hit = ({1'b0, sym_in} < (SYM_W + 1)'(SYMBOL_COUNT));
	assign len_sat = (len_in > LEN_IN_W'(LenLimit)) ? LEN_IN_W'(LenLimit) : len_in;

	assign in_ok = s_axis_tvalid && s_axis_tready;
	assign wr_en = in_ok && (func_in == FUNC_LOAD) && sym_hit;
	assign rd_en = in_ok && (func_in == FUNC_ENCODE);

	hcbp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SYMBOL_COUNT)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(sym_in[AW-1:0]),
		.wr_data({len_sat, code_in}),
		.rd_en  (rd_en),
		.rd_addr(sym_in[AW-1:0]),
		.rd_data(rd_data)
	);

	// packer control
	assign emit      = (cnt_q >= CNT_W'(BYTE_W)) && (!out_valid_q || m_axis_tready);
	assign cnt_after = emit ? (cnt_q - CNT_W'(BYTE_W)) : cnt_q;
	assign take      = valid_s1 && (cnt_after < CNT_W'(BYTE_W));
	assign s_axis_tready = !valid_s1 || take;

	assign len_rd  = rd_data[CODE_W +: LEN_IN_W];
	assign len_use = !hit_s1 ? '0 :
		(len_rd > LEN_IN_W'(LenLimit)) ? LEN_W'(LenLimit) : LEN_W'(len_rd);
	assign code_m  = rd_data[CODE_W-1:0] & ~({CODE_W{1'b1}} << len_use);
	assign emit_sh = acc_q >> (cnt_q - CNT_W'(BYTE_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= in_ok && ((func_in == FUNC_ENCODE) || (func_in == FUNC_FLUSH));
		end
	end

	always_ff @(posedge clk) begin
		if (in_ok) begin
			flush_s1 <= (func_in == FUNC_FLUSH);
			hit_s1   <= sym_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pad_q <= '0;
		end else if (take && !flush_s1) begin
			cnt_q <= cnt_after + CNT_W'(len_use);
			pad_q <= '0;
		end else if (take && (cnt_after != '0)) begin
			cnt_q <= CNT_W'(BYTE_W);
			pad_q <= PAD_W'(CNT_W'(BYTE_W) - cnt_after);
		end else begin
			cnt_q <= cnt_after;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !flush_s1) begin
			acc_q <= ACC_W'(acc_q << len_use) | ACC_W'(code_m);
		end else if (take && (cnt_after != '0)) begin
			acc_q <= ACC_W'(acc_q << (CNT_W'(BYTE_W) - cnt_after));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_sh[BYTE_W-1:0];
			out_last_q <= (cnt_after < CNT_W'(BYTE_W));
			out_pad_q  <= pad_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_pad_q;

	a_take_drained: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (cnt_after < CNT_W'(BYTE_W)) && !(emit && (cnt_q < CNT_W'(BYTE_W))))
		else $error("request merged while accumulator still holds a full byte");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ACC_W))
		else $error("accumulator bit count out of range");

	a_pad_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_pad_q != '0)) |-> out_last_q)
		else $error("padded byte not marked last");

	a_pad_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_q != '0) |-> (cnt_q == CNT_W'(BYTE_W)) || (cnt_q == '0) || $past(take))
		else $error("pad count held with encoded bits pending");

endmodule
